FILE: src/lfpm_pkg.sv
// lfpm_pkg: widths, register indexes, reset values and controller states
// shared by the line follower pid / motor mix block and its interfaces.
// no dependencies.
`timescale 1ns / 1ps

package lfpm_pkg;

	// field widths
	localparam int POS_W   = 13;
	localparam int ERR_W   = 14;
	localparam int DIF_W   = 15;
	localparam int SUM_W   = 32;
	localparam int GAIN_W  = 16;
	localparam int SPD_W   = 8;
	localparam int ACC_W   = 50;
	localparam int CORR_W  = ACC_W - 8;
	localparam int NUM_W   = 17;
	localparam int DVD_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_SETPOINT  = 3'd3,
		REG_MAX_SPEED = 3'd4,
		REG_MIN_SPEED = 3'd5
	} cfg_reg_t;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd26;
	localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd0;
	localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd0;
	localparam logic [POS_W-1:0]  SETPOINT_RST  = 13'd2500;
	localparam logic [SPD_W-1:0]  MAX_SPEED_RST = 8'd220;
	localparam logic [SPD_W-1:0]  MIN_SPEED_RST = 8'd170;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_CORR,
		ST_MIX,
		ST_PROD,
		ST_DSTART,
		ST_DIV,
		ST_OUT
	} fsm_state_t;

endpackage

FILE: src/lfpm_if.sv
// lfpm_pos_if / lfpm_spd_if: valid-ready channels for line position samples
// and motor speed results. depends on lfpm_pkg for field widths.
`timescale 1ns / 1ps

interface lfpm_pos_if import lfpm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] line_position;

	modport source (output valid, output line_position, input ready);
	modport sink   (input valid, input line_position, output ready);
endinterface

interface lfpm_spd_if import lfpm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SPD_W-1:0] left_speed;
	logic [SPD_W-1:0] right_speed;

	modport source (output valid, output left_speed, output right_speed, input ready);
	modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

FILE: src/lfpm_mac.sv
// lfpm_mac: bit-serial pid multiply-accumulate, one gain bit per cycle, msb first.
// acc = gain_p*err + gain_i*sum + gain_d*dif. depends on lfpm_pkg.
`timescale 1ns / 1ps

module lfpm_mac import lfpm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [GAIN_W-1:0]        gain_p,
	input  logic [GAIN_W-1:0]        gain_i,
	input  logic [GAIN_W-1:0]        gain_d,
	input  logic signed [ERR_W-1:0]  err,
	input  logic signed [SUM_W-1:0]  sum,
	input  logic signed [DIF_W-1:0]  dif,
	output logic signed [ACC_W-1:0]  acc,
	output logic                     done
);

	localparam int PART_W = SUM_W + 2;
	localparam int CNT_W  = $clog2(GAIN_W);

	logic [GAIN_W-1:0]        gp_q, gi_q, gd_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [DIF_W-1:0]  dif_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic signed [PART_W-1:0] term_p, term_i, term_d, part;

	// select operands by the current top gain bits
	always_comb begin
		term_p = gp_q[GAIN_W-1] ? PART_W'(err_q) : '0;
		term_i = gi_q[GAIN_W-1] ? PART_W'(sum_q) : '0;
		term_d = gd_q[GAIN_W-1] ? PART_W'(dif_q) : '0;
		part   = term_p + term_i + term_d;
	end

	// control: iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(GAIN_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: gain shift registers and shift-add accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			gp_q  <= gain_p;
			gi_q  <= gain_i;
			gd_q  <= gain_d;
			err_q <= err;
			sum_q <= sum;
			dif_q <= dif;
			acc_q <= '0;
		end else if (busy_q) begin
			gp_q  <= {gp_q[GAIN_W-2:0], 1'b0};
			gi_q  <= {gi_q[GAIN_W-2:0], 1'b0};
			gd_q  <= {gd_q[GAIN_W-2:0], 1'b0};
			acc_q <= (acc_q <<< 1) + ACC_W'(part);
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

FILE: src/lfpm_div.sv
// lfpm_div: restoring divider, one quotient bit per cycle, 16-bit dividend
// by 8-bit divisor; flags a nonzero remainder. depends on lfpm_pkg.
`timescale 1ns / 1ps

module lfpm_div import lfpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [SPD_W-1:0]  divisor,
	output logic [DVD_W-1:0]  quotient,
	output logic              rem_nz,
	output logic              done
);

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [SPD_W-1:0] dvs_q;
	logic [SPD_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SPD_W:0]   rem_sh;
	logic [SPD_W:0]   diff;
	logic             fits;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh = {rem_q, quo_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		fits   = rem_sh >= {1'b0, dvs_q};
	end

	// control: iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DVD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[SPD_W-1:0] : rem_sh[SPD_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign rem_nz   = |rem_q;
	assign done     = done_q;

endmodule

FILE: src/line_follow_pid_motor_mix.sv
// line_follow_pid_motor_mix: pid steering controller with differential motor mix.
// depends on lfpm_pkg, lfpm_if (channels), lfpm_mac and lfpm_div.
//
// usage:
//   sample (valid/ready sink) takes one 13-bit line position per beat.
//   drive (valid/ready source) returns one beat with left and right speed.
//   cfg_we/cfg_idx/cfg_data write the gains, setpoint and speed limits;
//   write them only while no sample is in flight. unknown indexes are ignored.
// timing:
//   a sample runs through the bit-serial pid accumulate (one gain bit per
//   cycle), steps for rounding, clamping and mixing, the remap product and
//   the restoring divider of the speed remap, then is loaded into the output
//   register; the next sample is accepted only once that result is loaded.
// reset:
//   arst_n clears the integral and previous error, loads the default
//   registers and empties the output register.
// stalls:
//   the output register holds a finished beat while drive.ready is low; the
//   next sample is still accepted and runs until its own result is ready,
//   then waits in the last step until the output register frees up.
`timescale 1ns / 1ps

module line_follow_pid_motor_mix import lfpm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	lfpm_pos_if.sink             sample,
	lfpm_spd_if.source           drive
);

	// configuration registers
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [POS_W-1:0]  setpoint_q;
	logic [SPD_W-1:0]  max_speed_q, min_speed_q;

	// controller state
	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0] prev_err_q;
	fsm_state_t              state_q, state_d;

	// datapath registers
	logic signed [CORR_W-1:0] corr_full_q;
	logic [SPD_W-1:0]         left_q, right_q;
	logic signed [NUM_W-1:0]  num_l_q, num_r_q;
	logic                     out_valid_q;
	logic [SPD_W-1:0]         left_out_q, right_out_q;

	// handshake and control
	logic accept;
	logic in_ready;
	logic out_free;
	logic div_start;
	logic out_load;

	// error terms of the incoming sample
	logic signed [ERR_W-1:0] err;
	logic signed [DIF_W-1:0] dif;
	logic signed [SUM_W:0]   sum_wide;
	logic signed [SUM_W-1:0] sum_sat;

	// unit results
	logic signed [ACC_W-1:0] acc;
	logic                    mac_done;
	logic [DVD_W-1:0]        quo_l, quo_r;
	logic                    rnz_l, rnz_r;
	logic                    div_done_l, div_done_r;

	// stage logic
	logic signed [ACC_W-1:0]  acc_adj;
	logic signed [CORR_W-1:0] mx_wide;
	logic signed [SPD_W:0]    mx9, corr9;
	logic signed [SPD_W+1:0]  left_sum, right_sum;
	logic signed [SPD_W:0]    span;
	logic signed [2*SPD_W+1:0] prod_l, prod_r;
	logic [NUM_W-1:0]         mag_l, mag_r;
	logic [SPD_W-1:0]         spd_l, spd_r;

	assign accept   = sample.valid && in_ready;
	assign out_free = !out_valid_q || drive.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= GAIN_P_RST;
			gain_i_q    <= GAIN_I_RST;
			gain_d_q    <= GAIN_D_RST;
			setpoint_q  <= SETPOINT_RST;
			max_speed_q <= MAX_SPEED_RST;
			min_speed_q <= MIN_SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_GAIN_P:    gain_p_q    <= cfg_data;
				REG_GAIN_I:    gain_i_q    <= cfg_data;
				REG_GAIN_D:    gain_d_q    <= cfg_data;
				REG_SETPOINT:  setpoint_q  <= cfg_data[POS_W-1:0];
				REG_MAX_SPEED: max_speed_q <= cfg_data[SPD_W-1:0];
				REG_MIN_SPEED: min_speed_q <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	// error, derivative difference and saturated integral
	always_comb begin
		err      = $signed({1'b0, sample.line_position}) - $signed({1'b0, setpoint_q});
		dif      = DIF_W'(err) - DIF_W'(prev_err_q);
		sum_wide = (SUM_W + 1)'(error_sum_q) + (SUM_W + 1)'(err);
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	// integral and previous error update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else if (accept) begin
			error_sum_q <= sum_sat;
			prev_err_q  <= err;
		end
	end

	// pid accumulate
	lfpm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.gain_p (gain_p_q),
		.gain_i (gain_i_q),
		.gain_d (gain_d_q),
		.err    (err),
		.sum    (sum_sat),
		.dif    (dif),
		.acc    (acc),
		.done   (mac_done)
	);

	// divide by 256 toward zero, clamp, mix and remap product
	always_comb begin
		acc_adj   = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
		mx_wide   = CORR_W'($signed({1'b0, max_speed_q}));
		mx9       = $signed({1'b0, max_speed_q});
		if (corr_full_q > mx_wide) begin
			corr9 = mx9;
		end else if (corr_full_q < -mx_wide) begin
			corr9 = -mx9;
		end else begin
			corr9 = corr_full_q[SPD_W:0];
		end
		left_sum  = (SPD_W + 2)'(mx9) + (SPD_W + 2)'(corr9);
		right_sum = (SPD_W + 2)'(mx9) - (SPD_W + 2)'(corr9);
		span      = $signed({1'b0, max_speed_q}) - $signed({1'b0, min_speed_q});
		prod_l    = span * $signed({1'b0, left_q});
		prod_r    = span * $signed({1'b0, right_q});
		mag_l     = num_l_q[NUM_W-1] ? -num_l_q : num_l_q;
		mag_r     = num_r_q[NUM_W-1] ? -num_r_q : num_r_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CORR) begin
			corr_full_q <= $signed(acc_adj[ACC_W-1:8]);
		end
		if (state_q == ST_MIX) begin
			left_q  <= corr9[SPD_W] ? left_sum[SPD_W-1:0] : max_speed_q;
			right_q <= corr9[SPD_W] ? max_speed_q : right_sum[SPD_W-1:0];
		end
		if (state_q == ST_PROD) begin
			num_l_q <= prod_l[NUM_W-1:0];
			num_r_q <= prod_r[NUM_W-1:0];
		end
	end

	// floor division by max speed, one lane per motor
	lfpm_div u_div_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_l[DVD_W-1:0]),
		.divisor  (max_speed_q),
		.quotient (quo_l),
		.rem_nz   (rnz_l),
		.done     (div_done_l)
	);

	lfpm_div u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_r[DVD_W-1:0]),
		.divisor  (max_speed_q),
		.quotient (quo_r),
		.rem_nz   (rnz_r),
		.done     (div_done_r)
	);

	// final speeds: min plus floored quotient, min alone at zero max
	always_comb begin
		if (max_speed_q == '0) begin
			spd_l = min_speed_q;
			spd_r = min_speed_q;
		end else begin
			spd_l = num_l_q[NUM_W-1] ? (min_speed_q - quo_l[SPD_W-1:0] - SPD_W'(rnz_l))
			                         : (min_speed_q + quo_l[SPD_W-1:0]);
			spd_r = num_r_q[NUM_W-1] ? (min_speed_q - quo_r[SPD_W-1:0] - SPD_W'(rnz_r))
			                         : (min_speed_q + quo_r[SPD_W-1:0]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (sample.valid) state_d = ST_MAC;
			ST_MAC:    if (mac_done) state_d = ST_CORR;
			ST_CORR:   state_d = ST_MIX;
			ST_MIX:    state_d = ST_PROD;
			ST_PROD:   state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DIV;
			ST_DIV:    if (div_done_l && div_done_r) state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_DSTART);
		out_load  = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (drive.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_out_q  <= spd_l;
			right_out_q <= spd_r;
		end
	end

	assign sample.ready      = in_ready;
	assign drive.valid       = out_valid_q;
	assign drive.left_speed  = left_out_q;
	assign drive.right_speed = right_out_q;

endmodule

FILE: src/lfpm_chk.sv
// lfpm_chk: port-level checks on the pid motor mix channels, bound to the top.
// depends on lfpm_pkg and the lfpm_if channel interfaces.
`timescale 1ns / 1ps

module lfpm_chk import lfpm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	lfpm_pos_if.sink   sample,
	lfpm_spd_if.source drive
);

	// a stalled result beat stays up
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && !drive.ready |=> drive.valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its speeds
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && !drive.ready |=> $stable(drive.left_speed) && $stable(drive.right_speed))
		else $error("result speeds changed while stalled");

	// one sample at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("sample accepted while previous one in flight");

	// no result can come out the cycle after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !$rose(drive.valid))
		else $error("result appeared too early");

	// a fresh result is only loaded while the input side is busy
	a_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive.valid) |-> !$past(sample.ready))
		else $error("result loaded while idle");

endmodule

bind line_follow_pid_motor_mix lfpm_chk u_lfpm_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.sample (sample),
	.drive  (drive)
);

FILE: test/line_follow_pid_motor_mix_tb.sv
// line_follow_pid_motor_mix_tb: self-checking bench for the pid steering / motor mix block.
// predicts left and right speeds per line position beat and compares them in order.
// depends on lfpm_pkg, lfpm_if and line_follow_pid_motor_mix.
`timescale 1ns / 1ps

module line_follow_pid_motor_mix_tb;
	import lfpm_pkg::*;

	// writes to these indexes must leave every register alone
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 50;
	localparam int RAND_PHASES   = 9;
	localparam int PHASE_ITEMS   = 55;

	typedef struct packed {
		logic [SPD_W-1:0] left;
		logic [SPD_W-1:0] right;
	} motor_cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	lfpm_pos_if pos_ch ();
	lfpm_spd_if spd_ch ();

	line_follow_pid_motor_mix uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.sample  (pos_ch),
		.drive   (spd_ch)
	);

	// register copies and controller state for the predictor
	logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [POS_W-1:0] target_pos;
	logic [SPD_W-1:0] top_spd, floor_spd;
	logic signed [SUM_W-1:0] err_sum;
	logic signed [ERR_W-1:0] prev_err;

	logic [POS_W-1:0] sample_backlog[$];
	motor_cmd_t speed_due[$];
	int send_idle_pct;
	int ready_idle_pct;
	int n_bad;
	int beat_count;
	int quiet_cycles;

	always #10 clk = ~clk;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// linear remap of 0..max into min..max, floored
	function automatic logic [SPD_W-1:0] scale_speed(input longint s);
		longint m, n, num, q;
		m = longint'(top_spd);
		n = longint'(floor_spd);
		if (m == 0) return floor_spd;
		num = (m - n) * s;
		q = num / m;
		if (num < 0 && q * m != num) q = q - 1;
		return SPD_W'(n + q);
	endfunction

	// one pid step plus differential mix; advances the integral and last error
	function automatic motor_cmd_t pid_mix(input logic [POS_W-1:0] pos);
		longint err, sum, acc, corr, m;
		motor_cmd_t cmd;
		err = longint'(pos) - longint'(target_pos);
		sum = clip(longint'(err_sum) + err, -64'sd2147483648, 64'sd2147483647);
		acc = longint'(kp_q) * err + longint'(ki_q) * sum
			+ longint'(kd_q) * (err - longint'(prev_err));
		corr = acc / 256;
		m = longint'(top_spd);
		corr = clip(corr, -m, m);
		cmd.left = scale_speed(clip(m + corr, 0, m));
		cmd.right = scale_speed(clip(m - corr, 0, m));
		err_sum = sum[SUM_W-1:0];
		prev_err = err[ERR_W-1:0];
		return cmd;
	endfunction

	task automatic log_bad(input string what, input motor_cmd_t want, input motor_cmd_t got);
		n_bad++;
		if (n_bad <= 10)
			$display("beat %0d %s: left exp %0d got %0d, right exp %0d got %0d",
				beat_count, what, want.left, got.left, want.right, got.right);
	endtask

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			pos_ch.valid <= 1'b0;
		end else begin
			if (pos_ch.valid && pos_ch.ready)
				speed_due = {speed_due, pid_mix(pos_ch.line_position)};
			if (!pos_ch.valid || pos_ch.ready) begin
				if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pos_ch.valid <= 1'b1;
					pos_ch.line_position <= sample_backlog.pop_front();
				end else begin
					pos_ch.valid <= 1'b0;
				end
			end
		end
	end

	// speed monitor
	always @(posedge clk) begin
		motor_cmd_t got;
		if (!arst_n) begin
			spd_ch.ready <= 1'b0;
		end else begin
			if (spd_ch.valid && spd_ch.ready) begin
				got.left = spd_ch.left_speed;
				got.right = spd_ch.right_speed;
				if (speed_due.size() == 0) begin
					log_bad("unexpected", '0, got);
				end else if (speed_due[0] !== got) begin
					log_bad("mismatch", speed_due[0], got);
					void'(speed_due.pop_front());
				end else begin
					void'(speed_due.pop_front());
				end
				beat_count++;
			end
			spd_ch.ready <= ($urandom_range(99) >= ready_idle_pct);
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pos_ch.valid && pos_ch.ready) || (spd_ch.valid && spd_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_GAIN_P:    kp_q = val;
			REG_GAIN_I:    ki_q = val;
			REG_GAIN_D:    kd_q = val;
			REG_SETPOINT:  target_pos = val[POS_W-1:0];
			REG_MAX_SPEED: top_spd = val[SPD_W-1:0];
			REG_MIN_SPEED: floor_spd = val[SPD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_setting(input logic [CFG_W-1:0] gp, gi, gd, sp, mx, mn);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_SETPOINT, sp);
		write_reg(REG_MAX_SPEED, mx);
		write_reg(REG_MIN_SPEED, mn);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold off until every queued sample is sent and every speed beat is back
	task automatic drain();
		do @(negedge clk);
		while (sample_backlog.size() != 0 || pos_ch.valid || speed_due.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic push_list(input logic [POS_W-1:0] pos[]);
		foreach (pos[i]) sample_backlog = {sample_backlog, pos[i]};
		drain();
	endtask

	// mostly narrow values, now and then the whole range
	function automatic int pick(input int narrow, input int wide);
		if ($urandom_range(3) == 0) return $urandom_range(wide);
		return $urandom_range(narrow);
	endfunction

	// positions near the setpoint, across the track, or any 13-bit value
	function automatic logic [POS_W-1:0] next_position();
		int r, p;
		r = $urandom_range(9);
		if (r < 7) begin
			p = int'(target_pos) + $urandom_range(2400) - 1200;
			return POS_W'(clip(p, 0, 5000));
		end
		if (r < 9) return POS_W'($urandom_range(5000));
		return POS_W'($urandom_range(8191));
	endfunction

	initial begin
		int mx, mn;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		pos_ch.valid = 1'b0;
		pos_ch.line_position = '0;
		spd_ch.ready = 1'b0;
		kp_q = GAIN_P_RST;
		ki_q = GAIN_I_RST;
		kd_q = GAIN_D_RST;
		target_pos = SETPOINT_RST;
		top_spd = MAX_SPEED_RST;
		floor_spd = MIN_SPEED_RST;
		err_sum = '0;
		prev_err = '0;
		n_bad = 0;
		beat_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 29;
		ready_idle_pct = 49;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, track ends and beyond
		push_list('{13'd2500, 13'd0, 13'd5000, 13'd8191, 13'd4096, 13'd1, 13'd2501, 13'd2499});

		// all gains full scale, zero setpoint, widest speed span; spare indexes ignored
		load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd255, 16'd0);
		write_reg(REG_SPARE_6, 16'hFFFF);
		write_reg(REG_SPARE_7, 16'h0000);
		@(posedge clk);
		cfg_we <= 1'b0;
		push_list('{13'd0, 13'd8191, 13'd0, 13'd5000});

		// setpoint past the track end, min equal to max
		load_setting(16'h0100, 16'h0000, 16'h0080, 16'd8191, 16'd255, 16'd255);
		push_list('{13'd8191, 13'd0, 13'd4000});

		// zero max speed pins both sides to min
		load_setting(16'd26, 16'd0, 16'd0, 16'd2500, 16'd0, 16'd123);
		push_list('{13'd0, 13'd5000, 13'd2500});

		// min above max
		load_setting(16'h0040, 16'h0001, 16'h0200, 16'd2500, 16'd100, 16'd255);
		push_list('{13'd0, 13'd5000, 13'd2500, 13'd1000, 13'd4000});

		// random settings, idling swapped after a third of the phases and dropped for the last third
		for (int k = 0; k < RAND_PHASES; k++) begin
			if (k == RAND_PHASES / 3) begin
				send_idle_pct = 49;
				ready_idle_pct = 29;
			end else if (k == 2 * RAND_PHASES / 3) begin
				send_idle_pct = 0;
				ready_idle_pct = 0;
			end
			mx = $urandom_range(255);
			mn = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(mx);
			load_setting(CFG_W'(pick(600, 65535)), CFG_W'(pick(40, 65535)),
				CFG_W'(pick(1500, 65535)), CFG_W'(pick(5000, 8191)), CFG_W'(mx), CFG_W'(mn));
			for (int i = 0; i < PHASE_ITEMS; i++)
				sample_backlog = {sample_backlog, next_position()};
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_bad == 0 && speed_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
